// File: design/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the single-wire frame decoder
// Edge and status codes, frame geometry and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

	localparam int unsigned HANDSHAKE_EDGES = 2;
	localparam int unsigned DECODE_EDGES    = 80;
	localparam int unsigned FRAME_BITS      = 40;

	localparam int unsigned WORD_W      = 40;
	localparam int unsigned TS_W        = 64;
	localparam int unsigned THR_W       = 32;
	localparam int unsigned HS_CNT_W    = 2;
	localparam int unsigned DEC_CNT_W   = 7;
	localparam int unsigned BIT_IDX_W   = 6;
	localparam int unsigned BYTE_W      = 8;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd60000;

	typedef enum logic [1:0] {
		EDGE_FALL = 2'd0,
		EDGE_RISE = 2'd1
	} edge_kind_t;

	typedef enum logic [1:0] {
		STATUS_PENDING = 2'd0,
		STATUS_GOOD    = 2'd1,
		STATUS_BAD     = 2'd2,
		STATUS_ABORTED = 2'd3
	} status_t;

	typedef struct packed {
		status_t               status;
		logic [BYTE_W-1:0]     humidity_int;
		logic [BYTE_W-1:0]     humidity_frac;
		logic [BYTE_W-1:0]     temp_int;
		logic [BYTE_W-1:0]     temp_frac;
		logic [BYTE_W-1:0]     received_checksum;
		logic [BIT_IDX_W-1:0]  bits_received;
	} result_t;

endpackage

`default_nettype wire

// File: design/sfd_core.sv
// ----------------------------------------------------------------------------
// sfd_core: frame state and edge decode
// Holds the frame state, applies one edge transaction per step and presents
// the result for the state after that step.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire logic                              func,
	input  wire logic [1:0]                        edge_kind,
	input  wire logic [sfd_pkg::TS_W-1:0]          timestamp_ns,
	input  wire logic [sfd_pkg::THR_W-1:0]         one_threshold_ns,
	output sfd_pkg::result_t                       result
);

	logic [sfd_pkg::HS_CNT_W-1:0]  hs_cnt_q, hs_cnt_d;
	logic [sfd_pkg::DEC_CNT_W-1:0] dec_cnt_q, dec_cnt_d;
	logic [sfd_pkg::TS_W-1:0]      rise_time_q, rise_time_d;
	logic                          rise_valid_q, rise_valid_d;
	logic [sfd_pkg::BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
	logic [sfd_pkg::WORD_W-1:0]    word_q, word_d;
	logic                          aborted_q, aborted_d;

	logic [sfd_pkg::TS_W-1:0]      pulse;
	logic                          one_bit;
	logic [sfd_pkg::BYTE_W-1:0]    sum;

	assign pulse   = timestamp_ns - rise_time_q;
	assign one_bit = pulse > {{(sfd_pkg::TS_W - sfd_pkg::THR_W){1'b0}}, one_threshold_ns};

	always_comb begin
		hs_cnt_d     = hs_cnt_q;
		dec_cnt_d    = dec_cnt_q;
		rise_time_d  = rise_time_q;
		rise_valid_d = rise_valid_q;
		bit_idx_d    = bit_idx_q;
		word_d       = word_q;
		aborted_d    = aborted_q;
		if (step) begin
			if (func) begin
				hs_cnt_d     = '0;
				dec_cnt_d    = '0;
				rise_time_d  = '0;
				rise_valid_d = 1'b0;
				bit_idx_d    = '0;
				word_d       = '0;
				aborted_d    = 1'b0;
			end else if (!aborted_q &&
					dec_cnt_q < sfd_pkg::DEC_CNT_W'(sfd_pkg::DECODE_EDGES)) begin
				if (hs_cnt_q < sfd_pkg::HS_CNT_W'(sfd_pkg::HANDSHAKE_EDGES)) begin
					hs_cnt_d = hs_cnt_q + 1'b1;
				end else begin
					case (edge_kind)
						sfd_pkg::EDGE_RISE: begin
							rise_time_d  = timestamp_ns;
							rise_valid_d = 1'b1;
							dec_cnt_d    = dec_cnt_q + 1'b1;
						end
						sfd_pkg::EDGE_FALL: begin
							if (rise_valid_q) begin
								if (bit_idx_q < sfd_pkg::BIT_IDX_W'(sfd_pkg::FRAME_BITS)) begin
									word_d = word_q | ({{(sfd_pkg::WORD_W-1){1'b0}}, one_bit}
										<< (sfd_pkg::BIT_IDX_W'(sfd_pkg::WORD_W - 1) - bit_idx_q));
									bit_idx_d = bit_idx_q + 1'b1;
								end
								rise_valid_d = 1'b0;
							end
							dec_cnt_d = dec_cnt_q + 1'b1;
						end
						default: begin
							aborted_d = 1'b1;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_cnt_q     <= '0;
			dec_cnt_q    <= '0;
			rise_time_q  <= '0;
			rise_valid_q <= 1'b0;
			bit_idx_q    <= '0;
			word_q       <= '0;
			aborted_q    <= 1'b0;
		end else begin
			hs_cnt_q     <= hs_cnt_d;
			dec_cnt_q    <= dec_cnt_d;
			rise_time_q  <= rise_time_d;
			rise_valid_q <= rise_valid_d;
			bit_idx_q    <= bit_idx_d;
			word_q       <= word_d;
			aborted_q    <= aborted_d;
		end
	end

	assign sum = word_d[39:32] + word_d[31:24] + word_d[23:16] + word_d[15:8];

	always_comb begin
		result.humidity_int      = word_d[39:32];
		result.humidity_frac     = word_d[31:24];
		result.temp_int          = word_d[23:16];
		result.temp_frac         = word_d[15:8];
		result.received_checksum = word_d[7:0];
		result.bits_received     = bit_idx_d;
		if (aborted_d) begin
			result.status = sfd_pkg::STATUS_ABORTED;
		end else if (dec_cnt_d >= sfd_pkg::DEC_CNT_W'(sfd_pkg::DECODE_EDGES)) begin
			result.status = (sum == word_d[7:0]) ? sfd_pkg::STATUS_GOOD : sfd_pkg::STATUS_BAD;
		end else begin
			result.status = sfd_pkg::STATUS_PENDING;
		end
	end

endmodule

`default_nettype wire

// File: design/single_wire_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_decoder: 40-bit pulse-width frame decoder
// Input register, then result register, between input transaction and result.
// Throughput: one transaction per cycle while m_tready accepts results, bounded
// by the 64-bit pulse subtract and threshold compare in the frame state update.
// Reset: asynchronous; clears the frame state and sets the threshold to 60000.
// Exactly one result transaction follows each input transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_sensor_frame_decoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sfd_pkg::THR_W-1:0]      cfg_wdata,    // one_threshold_ns
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [63:0]                    s_tdata,      // timestamp_ns
	input  wire logic [2:0]                     s_tuser,      // func, edge_kind
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [47:0]                    m_tdata,      // humidity_int,
	                                                          // humidity_frac, temp_int,
	                                                          // temp_frac, received_checksum,
	                                                          // bits_received, zero pad
	output      logic [1:0]                     m_tuser       // status
);

	logic [sfd_pkg::THR_W-1:0] threshold_q;

	logic                      valid_s1;
	logic                      func_s1;
	logic [1:0]                kind_s1;
	logic [sfd_pkg::TS_W-1:0]  ts_s1;

	logic                      valid_s2;
	sfd_pkg::result_t          result_s2;
	sfd_pkg::result_t          result;

	logic                      advance;

	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= sfd_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser[0];
			kind_s1 <= s_tuser[2:1];
			ts_s1   <= s_tdata;
		end
	end

	sfd_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (valid_s1 && advance),
		.func             (func_s1),
		.edge_kind        (kind_s1),
		.timestamp_ns     (ts_s1),
		.one_threshold_ns (threshold_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.status;
	assign m_tdata  = {2'b00,
	                   result_s2.bits_received,
	                   result_s2.received_checksum,
	                   result_s2.temp_frac,
	                   result_s2.temp_int,
	                   result_s2.humidity_frac,
	                   result_s2.humidity_int};

endmodule

`default_nettype wire

// File: sim/single_wire_sensor_frame_decoder_tb.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_decoder_tb: self-checking bench for the frame decoder
// A short directed table covers the handshake, stray edges, rise replacement,
// timestamp wrap, the threshold boundary and aborts. Random frames follow:
// clean frames with good or bad checksums, aborted, sloppy and cut-off frames,
// over several threshold settings. Every result transaction is compared
// field by field with a cycle-free prediction of the frame state.
// ----------------------------------------------------------------------------
module single_wire_sensor_frame_decoder_tb;

	localparam logic [1:0]  EDGE_UNKNOWN    = 2'd2;
	localparam logic [1:0]  EDGE_UNKNOWN_HI = 2'd3;
	localparam logic [63:0] TS_MAX          = '1;
	localparam int unsigned RESULT_LATENCY  = 2;
	localparam int unsigned PHASES          = 5;
	localparam int unsigned PHASE_ITEMS     = 70;
	localparam int unsigned HOLD_CYCLES     = 60;

	localparam sfd_pkg::result_t IDLE_RESULT =
		'{sfd_pkg::STATUS_PENDING, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 6'd0};
	localparam sfd_pkg::result_t ABORT_AT_3  =
		'{sfd_pkg::STATUS_ABORTED, 8'hA0, 8'd0, 8'd0, 8'd0, 8'd0, 6'd3};

	typedef enum int {FRAME_CLEAN, FRAME_ABORT, FRAME_SLOPPY, FRAME_CUT} frame_flavor_t;

	typedef struct {
		logic              start;
		logic [1:0]        kind;
		logic [63:0]       ts;
		logic              typed;
		sfd_pkg::result_t  want;
	} stim_row_t;

	typedef struct {
		logic [1:0]  kind;
		logic [63:0] ts;
	} line_edge_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [sfd_pkg::THR_W-1:0]    cfg_wdata = '0;
	logic                         s_tvalid  = 1'b0;
	logic                         s_tready;
	logic [63:0]                  s_tdata   = '0;
	logic [2:0]                   s_tuser   = '0;
	logic                         m_tvalid;
	logic                         m_tready  = 1'b0;
	logic [47:0]                  m_tdata;
	logic [1:0]                   m_tuser;

	// frame state of the predictor
	logic [sfd_pkg::THR_W-1:0]     thr_ns;
	logic [sfd_pkg::HS_CNT_W-1:0]  hs_cnt;
	logic [sfd_pkg::DEC_CNT_W-1:0] dec_cnt;
	logic [sfd_pkg::TS_W-1:0]      rise_ts;
	logic                          rise_ok;
	logic [sfd_pkg::BIT_IDX_W-1:0] bit_idx;
	logic [sfd_pkg::WORD_W-1:0]    frame;
	logic                          frame_aborted;

	sfd_pkg::result_t readout_q [$];
	int unsigned mismatches    = 0;
	int unsigned items_sent    = 0;
	int unsigned settings_used = 0;
	int unsigned seen_pending  = 0;
	int unsigned seen_good     = 0;
	int unsigned seen_bad      = 0;
	int unsigned seen_aborted  = 0;
	int unsigned hold_req      = 0;
	bit          no_gaps       = 1'b0;

	single_wire_sensor_frame_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_frame_model();
		hs_cnt        = '0;
		dec_cnt       = '0;
		rise_ts       = '0;
		rise_ok       = 1'b0;
		bit_idx       = '0;
		frame         = '0;
		frame_aborted = 1'b0;
	endfunction

	function automatic sfd_pkg::result_t frame_readout(logic start, logic [1:0] kind,
	                                                  logic [63:0] ts);
		sfd_pkg::result_t           r;
		logic [sfd_pkg::BYTE_W-1:0] sum;
		if (start) begin
			clear_frame_model();
		end else if (!frame_aborted && dec_cnt < sfd_pkg::DECODE_EDGES) begin
			if (hs_cnt < sfd_pkg::HANDSHAKE_EDGES) begin
				hs_cnt = hs_cnt + 1'b1;
			end else if (kind == sfd_pkg::EDGE_RISE) begin
				rise_ts = ts;
				rise_ok = 1'b1;
				dec_cnt = dec_cnt + 1'b1;
			end else if (kind == sfd_pkg::EDGE_FALL) begin
				if (rise_ok && bit_idx < sfd_pkg::FRAME_BITS) begin
					frame[sfd_pkg::WORD_W-1-bit_idx] = (ts - rise_ts) > 64'(thr_ns);
					bit_idx = bit_idx + 1'b1;
				end
				rise_ok = 1'b0;
				dec_cnt = dec_cnt + 1'b1;
			end else begin
				frame_aborted = 1'b1;
			end
		end
		r.humidity_int      = frame[39:32];
		r.humidity_frac     = frame[31:24];
		r.temp_int          = frame[23:16];
		r.temp_frac         = frame[15:8];
		r.received_checksum = frame[7:0];
		r.bits_received     = bit_idx;
		sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
		if (frame_aborted)
			r.status = sfd_pkg::STATUS_ABORTED;
		else if (dec_cnt >= sfd_pkg::DECODE_EDGES)
			r.status = (sum == frame[7:0]) ? sfd_pkg::STATUS_GOOD : sfd_pkg::STATUS_BAD;
		else
			r.status = sfd_pkg::STATUS_PENDING;
		return r;
	endfunction

	function automatic logic [63:0] pulse_len(logic one);
		logic [63:0] span;
		case ($urandom_range(3, 0))
			0: span = '0;
			1: span = {$urandom, $urandom} >> 1;
			default: span = $urandom_range(20000, 0);
		endcase
		if (one)
			return 64'(thr_ns) + 64'd1 + span;
		return (span == 0) ? 64'(thr_ns) : 64'($urandom_range(thr_ns, 0));
	endfunction

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		$display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
		mismatches++;
	endtask

	task automatic send_item(logic start, logic [1:0] kind, logic [63:0] ts);
		int unsigned gap;
		gap = no_gaps ? 0 : $urandom_range(5, 0);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {kind, start};
		s_tdata  <= ts;
		do @(posedge clk); while (!s_tready);
		readout_q.push_back(frame_readout(start, kind, ts));
		items_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (readout_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_threshold(logic [sfd_pkg::THR_W-1:0] value);
		wait_drained();
		repeat (RESULT_LATENCY + 2) @(posedge clk);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_ns = value;
		settings_used++;
	endtask

	task automatic drive_frame(frame_flavor_t flavor, bit pause_mid);
		line_edge_t        edges [$];
		logic [7:0]        data [4];
		logic [7:0]        csum;
		logic [39:0]       word;
		logic [63:0]       t;
		int unsigned       keep;
		foreach (data[k]) data[k] = 8'($urandom);
		csum = data[0] + data[1] + data[2] + data[3];
		if ($urandom_range(1, 0) == 0)
			csum = 8'($urandom);
		word = {data[0], data[1], data[2], data[3], csum};
		t = ($urandom_range(7, 0) == 0) ? TS_MAX - $urandom_range(2000000, 0)
		                                : {$urandom, $urandom};
		for (int b = 39; b >= 0; b--) begin
			if (flavor == FRAME_SLOPPY && $urandom_range(5, 0) == 0) begin
				edges.push_back('{sfd_pkg::EDGE_FALL, t});
				t += $urandom_range(50000, 0);
			end
			if (flavor == FRAME_SLOPPY && $urandom_range(5, 0) == 0) begin
				edges.push_back('{sfd_pkg::EDGE_RISE, t});
				t += $urandom_range(50000, 0);
			end
			edges.push_back('{sfd_pkg::EDGE_RISE, t});
			t += pulse_len(word[b]);
			edges.push_back('{sfd_pkg::EDGE_FALL, t});
			t += $urandom_range(80000, 0);
		end
		repeat ($urandom_range(3, 0))
			edges.push_back('{($urandom_range(1, 0) != 0) ? sfd_pkg::EDGE_RISE
			                                              : sfd_pkg::EDGE_FALL,
			                  {$urandom, $urandom}});
		if (flavor == FRAME_ABORT)
			edges.insert($urandom_range(edges.size() - 1, 0),
			             '{($urandom_range(1, 0) != 0) ? EDGE_UNKNOWN : EDGE_UNKNOWN_HI,
			               {$urandom, $urandom}});
		if (flavor == FRAME_CUT) begin
			keep = $urandom_range(60, 1);
			while (edges.size() > keep) void'(edges.pop_back());
		end

		send_item(1'b1, 2'($urandom), {$urandom, $urandom});
		repeat (sfd_pkg::HANDSHAKE_EDGES) send_item(1'b0, 2'($urandom), {$urandom, $urandom});
		foreach (edges[i]) begin
			if (pause_mid && i == edges.size() / 2)
				wait_drained();
			send_item(1'b0, edges[i].kind, edges[i].ts);
		end
		if (flavor == FRAME_CUT)
			repeat ($urandom_range(8, 3))
				send_item($urandom_range(7, 0) == 0, 2'($urandom), {$urandom, $urandom});
	endtask

	// result side: random back-pressure, with one long hold-off on request
	initial begin
		int unsigned gap;
		forever begin
			gap = (hold_req != 0) ? hold_req : no_gaps ? 0 : $urandom_range(5, 0);
			hold_req = 0;
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n && m_tvalid));
		end
	end

	always @(posedge clk) begin
		sfd_pkg::result_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {sfd_pkg::status_t'(m_tuser), m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
			       m_tdata[31:24], m_tdata[39:32], m_tdata[45:40]};
			case (got.status)
				sfd_pkg::STATUS_PENDING: seen_pending++;
				sfd_pkg::STATUS_GOOD:    seen_good++;
				sfd_pkg::STATUS_BAD:     seen_bad++;
				default:                 seen_aborted++;
			endcase
			if (readout_q.size() == 0) begin
				report_mismatch("unexpected result", '0, got);
			end else begin
				want = readout_q.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", want.status, got.status);
				if (got.humidity_int !== want.humidity_int)
					report_mismatch("humidity_int", want.humidity_int, got.humidity_int);
				if (got.humidity_frac !== want.humidity_frac)
					report_mismatch("humidity_frac", want.humidity_frac, got.humidity_frac);
				if (got.temp_int !== want.temp_int)
					report_mismatch("temp_int", want.temp_int, got.temp_int);
				if (got.temp_frac !== want.temp_frac)
					report_mismatch("temp_frac", want.temp_frac, got.temp_frac);
				if (got.received_checksum !== want.received_checksum)
					report_mismatch("received_checksum", want.received_checksum,
					                got.received_checksum);
				if (got.bits_received !== want.bits_received)
					report_mismatch("bits_received", want.bits_received, got.bits_received);
			end
		end
	end

	initial begin
		#2000000;
		$display("timeout at %0t", $time);
		$display("single_wire_sensor_frame_decoder_tb: FAIL");
		$finish;
	end

	initial begin
		stim_row_t                 dir_rows [21];
		logic [sfd_pkg::THR_W-1:0] thr_plan [PHASES];
		int unsigned               r;
		int unsigned               phase_end;
		frame_flavor_t             flavor;

		clear_frame_model();
		thr_ns = sfd_pkg::THRESHOLD_RESET;
		dir_rows = '{
			'{1'b0, sfd_pkg::EDGE_RISE, TS_MAX,                  1'b1, IDLE_RESULT},
			'{1'b1, EDGE_UNKNOWN_HI,    TS_MAX,                  1'b1, IDLE_RESULT},
			'{1'b0, EDGE_UNKNOWN,       64'd0,                   1'b1, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_FALL, TS_MAX,                  1'b1, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_FALL, 64'd500,                 1'b1, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_RISE, 64'd0,                   1'b1, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_FALL, 64'd60001,               1'b0, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_RISE, 64'd100,                 1'b0, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_RISE, 64'd200,                 1'b0, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_FALL, 64'd60200,               1'b0, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_RISE, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_FALL, 64'd100000,              1'b0, IDLE_RESULT},
			'{1'b0, EDGE_UNKNOWN,       64'd0,                   1'b1, ABORT_AT_3},
			'{1'b0, sfd_pkg::EDGE_RISE, TS_MAX,                  1'b1, ABORT_AT_3},
			'{1'b1, sfd_pkg::EDGE_FALL, 64'd0,                   1'b1, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_FALL, TS_MAX,                  1'b1, IDLE_RESULT},
			'{1'b0, EDGE_UNKNOWN_HI,    64'd0,                   1'b1, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_RISE, 64'd0,                   1'b1, IDLE_RESULT},
			'{1'b0, sfd_pkg::EDGE_FALL, TS_MAX,                  1'b0, IDLE_RESULT},
			'{1'b0, EDGE_UNKNOWN_HI,    TS_MAX,                  1'b0, IDLE_RESULT},
			'{1'b1, sfd_pkg::EDGE_RISE, TS_MAX,                  1'b1, IDLE_RESULT}
		};
		thr_plan = '{32'd0, 32'hFFFF_FFFF, sfd_pkg::THRESHOLD_RESET, $urandom,
		             $urandom_range(100000, 20)};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].start, dir_rows[i].kind, dir_rows[i].ts);
			if (dir_rows[i].typed)
				readout_q[readout_q.size() - 1] = dir_rows[i].want;
		end

		// phase 1: long hold on results; phase 2: drain mid-frame; phase 3: no gaps
		for (int phase = 0; phase < PHASES; phase++) begin
			set_threshold(thr_plan[phase]);
			no_gaps = (phase == 3);
			if (phase == 1)
				hold_req = HOLD_CYCLES;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				r = $urandom_range(9, 0);
				if (r < 6)
					flavor = FRAME_CLEAN;
				else if (r == 6)
					flavor = FRAME_ABORT;
				else if (r < 9)
					flavor = FRAME_SLOPPY;
				else
					flavor = FRAME_CUT;
				drive_frame(flavor, phase == 2);
			end
		end
		no_gaps = 1'b0;

		wait_drained();
		repeat (RESULT_LATENCY + 4) @(posedge clk);
		$display("covered %0d input transactions over %0d threshold settings",
		         items_sent, settings_used);
		$display("results: %0d pending, %0d checksum good, %0d checksum bad, %0d aborted",
		         seen_pending, seen_good, seen_bad, seen_aborted);
		if (mismatches == 0)
			$display("single_wire_sensor_frame_decoder_tb: PASS");
		else
			$display("single_wire_sensor_frame_decoder_tb: FAIL");
		$finish;
	end

endmodule
